>>> design/mpmq_pkg.sv
package mpmq_pkg;
    localparam int Ports = 16;
    localparam int Nodes = 256;
    localparam int MsgBits = 32;
    localparam int PortW = $clog2(Ports);
    localparam int NodeW = $clog2(Nodes);
    localparam int CntW = $clog2(Nodes + 1);

    localparam logic [2:0] FUNC_CREATE  = 3'd0;
    localparam logic [2:0] FUNC_SEND    = 3'd1;
    localparam logic [2:0] FUNC_RECEIVE = 3'd2;
    localparam logic [2:0] FUNC_COUNT   = 3'd3;
    localparam logic [2:0] FUNC_DELETE  = 3'd4;
    localparam logic [2:0] FUNC_RESET   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd1;
    localparam logic [2:0] ST_NO_PORT  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_NO_NODE  = 3'd5;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         port;
        logic [8:0]         capacity;
        logic signed [31:0] msg;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         port_out;
        logic signed [31:0] msg_out;
        logic [8:0]         count_out;
    } t_rsp;

    typedef struct packed {
        logic             we;
        logic [NodeW-1:0] waddr;
        logic [NodeW-1:0] wlink;
        logic             wmsg_en;
        logic [MsgBits-1:0] wmsg;
        logic [NodeW-1:0] raddr;
    } t_node_ctl;
endpackage

>>> design/mpmq_if.sv
interface mpmq_req_if import mpmq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mpmq_rsp_if import mpmq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/mpmq_node_mem.sv
module mpmq_node_mem import mpmq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_node_ctl          i_ctl,
    output logic [NodeW-1:0]   o_link,
    output logic [MsgBits-1:0] o_msg
);
    // links use a fill mark: entries at or above it still hold the reset chain
    logic [NodeW-1:0]   r_link_mem [Nodes];
    logic [MsgBits-1:0] r_msg_mem [Nodes];
    logic [CntW-1:0]    r_fill;
    logic [NodeW-1:0]   r_link_q;
    logic               r_fresh;
    logic [NodeW-1:0]   r_raddr;
    logic [CntW-1:0]    n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.we && {1'b0, i_ctl.waddr} >= r_fill) begin
            n_fill = {1'b0, i_ctl.waddr} + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // a write at or above the mark moves the mark just past it; entries skipped over are not filled
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_link_mem[i_ctl.waddr] <= i_ctl.wlink;
        end
        if (i_ctl.wmsg_en) begin
            r_msg_mem[i_ctl.waddr] <= i_ctl.wmsg;
        end
        r_link_q <= r_link_mem[i_ctl.raddr];
        o_msg    <= r_msg_mem[i_ctl.raddr];
        r_raddr  <= i_ctl.raddr;
        r_fresh  <= ({1'b0, i_ctl.raddr} >= r_fill) && !(i_ctl.we && i_ctl.waddr == i_ctl.raddr);
    end

    assign o_link = r_fresh ? r_raddr + NodeW'(1) : r_link_q;
endmodule

>>> design/multi_port_message_queue_manager.sv
// Message queue manager for 16 ports sharing a pool of 256 linked nodes.
// One request is handled at a time and gives exactly one response. Count,
// delete, reset and error cases go from execute to response state; send
// and receive pass the memory state (one registered read of the node
// memory), and create the scan state, which examines up to 16 ports
// downward. A new request is taken once the previous response has been
// moved into the output register. No clearing pass is needed after reset.
module multi_port_message_queue_manager import mpmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mpmq_req_if.sink   i_req,
    mpmq_rsp_if.source o_rsp
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_MEM  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state r_state;
    t_req   r_req;
    t_rsp   r_rsp;
    t_rsp   r_out;
    logic   r_out_valid;

    logic [Ports-1:0] r_alloc;
    logic [NodeW-1:0] r_head [Ports];
    logic [NodeW-1:0] r_tail [Ports];
    logic [CntW-1:0]  r_len [Ports];
    logic [CntW-1:0]  r_cap [Ports];
    logic [NodeW-1:0] r_free_head;
    logic [CntW-1:0]  r_free_cnt;
    logic [PortW-1:0] r_scan;
    logic [PortW-1:0] r_scan_start;
    logic [PortW:0]   r_scan_n;
    logic [NodeW-1:0] r_node;

    t_node_ctl        w_ctl;
    logic [NodeW-1:0] w_link;
    logic [MsgBits-1:0] w_msg;
    logic [PortW-1:0] w_p;
    logic             w_valid;

    assign w_p = r_req.port[PortW-1:0];
    assign w_valid = r_alloc[w_p];

    mpmq_node_mem u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .o_link (w_link),
        .o_msg  (w_msg)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        w_ctl = '0;
        w_ctl.wmsg = r_req.msg;
        w_ctl.raddr = r_free_head;
        if (r_state == S_EXEC && w_valid) begin
            case (r_req.func)
                FUNC_SEND: begin
                    w_ctl.raddr = r_free_head;
                    if (r_len[w_p] < r_cap[w_p] && r_free_cnt != '0) begin
                        w_ctl.wmsg_en = 1'b1;
                        w_ctl.waddr = r_free_head;
                        if (r_len[w_p] != '0) begin
                            w_ctl.we = 1'b1;
                            w_ctl.waddr = r_tail[w_p];
                            w_ctl.wlink = r_free_head;
                            w_ctl.wmsg_en = 1'b0;
                        end
                    end
                end
                FUNC_RECEIVE: w_ctl.raddr = r_head[w_p];
                FUNC_DELETE, FUNC_RESET: begin
                    if (r_len[w_p] != '0) begin
                        w_ctl.we = 1'b1;
                        w_ctl.waddr = r_tail[w_p];
                        w_ctl.wlink = r_free_head;
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_MEM) begin
            if (r_req.func == FUNC_SEND) begin
                w_ctl.wmsg_en = 1'b1;
                w_ctl.waddr = r_node;
            end else begin
                w_ctl.we = 1'b1;
                w_ctl.waddr = r_node;
                w_ctl.wlink = r_free_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_alloc <= '0;
            for (int i = 0; i < Ports; i++) r_len[i] <= '0;
            r_free_head <= '0;
            r_free_cnt <= CntW'(Nodes);
            r_scan <= PortW'(Ports - 1);
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rsp <= '0;
                    r_state <= S_RESP;
                    if (r_req.func == FUNC_CREATE) begin
                        r_rsp.status <= ST_NO_PORT;
                        r_scan_start <= r_scan;
                        r_scan_n <= '0;
                        r_state <= S_SCAN;
                    end else if (r_req.func > FUNC_RESET || !w_valid
                                 || {1'b0, r_req.port} >= 5'(Ports)) begin
                        r_rsp.status <= ST_NOT_ALLOC;
                    end else begin
                        case (r_req.func)
                            FUNC_SEND: begin
                                if (r_len[w_p] >= r_cap[w_p]) begin
                                    r_rsp.status <= ST_FULL;
                                end else if (r_free_cnt == '0) begin
                                    r_rsp.status <= ST_NO_NODE;
                                end else begin
                                    r_node <= r_free_head;
                                    if (r_len[w_p] == '0) r_head[w_p] <= r_free_head;
                                    r_tail[w_p] <= r_free_head;
                                    r_len[w_p] <= r_len[w_p] + CntW'(1);
                                    r_free_cnt <= r_free_cnt - CntW'(1);
                                    r_state <= S_MEM;
                                end
                            end
                            FUNC_RECEIVE: begin
                                if (r_len[w_p] == '0) begin
                                    r_rsp.status <= ST_EMPTY;
                                end else begin
                                    r_node <= r_head[w_p];
                                    r_len[w_p] <= r_len[w_p] - CntW'(1);
                                    if (r_free_cnt < CntW'(Nodes))
                                        r_free_cnt <= r_free_cnt + CntW'(1);
                                    r_state <= S_MEM;
                                end
                            end
                            FUNC_COUNT: r_rsp.count_out <= r_len[w_p];
                            default: begin
                                if (r_len[w_p] != '0) begin
                                    r_free_head <= r_head[w_p];
                                    if (r_free_cnt + r_len[w_p] > CntW'(Nodes))
                                        r_free_cnt <= CntW'(Nodes);
                                    else
                                        r_free_cnt <= r_free_cnt + r_len[w_p];
                                end
                                r_len[w_p] <= '0;
                                if (r_req.func == FUNC_DELETE) r_alloc[w_p] <= 1'b0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_scan <= (r_scan == '0) ? PortW'(Ports - 1) : r_scan - PortW'(1);
                    r_scan_n <= r_scan_n + (PortW + 1)'(1);
                    if (!r_alloc[r_scan]) begin
                        r_alloc[r_scan] <= 1'b1;
                        r_len[r_scan] <= '0;
                        r_cap[r_scan] <= r_req.capacity;
                        r_rsp.status <= ST_OK;
                        r_rsp.port_out <= 4'(r_scan);
                        r_state <= S_RESP;
                    end else if (r_scan_n == (PortW + 1)'(Ports - 1)) begin
                        r_scan <= r_scan_start;
                        r_state <= S_RESP;
                    end
                end
                S_MEM: begin
                    if (r_req.func == FUNC_SEND) begin
                        r_free_head <= w_link;
                    end else begin
                        r_rsp.msg_out <= w_msg;
                        r_head[w_p] <= w_link;
                        r_free_head <= r_node;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out <= r_rsp;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready) else $error("overlapped request");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CntW'(Nodes)) else $error("free count overflow");
    a_rsp_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && (!r_out_valid || o_rsp.ready)) |=> r_out_valid)
        else $error("response lost");
endmodule

>>> bench/tb_multi_port_message_queue_manager.sv
module tb_multi_port_message_queue_manager;
    import mpmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mpmq_req_if req_if ();
    mpmq_rsp_if rsp_if ();

    multi_port_message_queue_manager u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // queue state mirror
    logic             q_alloc [Ports];
    logic [NodeW-1:0] q_head [Ports];
    logic [NodeW-1:0] q_tail [Ports];
    int unsigned      q_len [Ports];
    int unsigned      q_cap [Ports];
    logic [NodeW-1:0] link_mem [Nodes];
    logic [31:0]      word_mem [Nodes];
    logic [NodeW-1:0] free_head;
    int unsigned      free_cnt;
    logic [PortW-1:0] scan_ptr;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];

    int  mismatches = 0;
    bit  stim_done = 1'b0;
    bit  quiet_send = 1'b0;
    bit  quiet_recv = 1'b0;
    int  hold_off = 0;

    function automatic void splice_free(int p);
        if (q_len[p] > 0) begin
            link_mem[q_tail[p]] = free_head;
            free_head = q_head[p];
            free_cnt += q_len[p];
            if (free_cnt > Nodes) free_cnt = Nodes;
        end
        q_len[p] = 0;
    endfunction

    function automatic t_rsp queue_op(t_req r);
        t_rsp o;
        int p;
        int cand;
        logic [NodeW-1:0] nd;
        bit ok;
        o = '0;
        p = r.port;
        ok = q_alloc[p];
        case (r.func)
            FUNC_CREATE: begin
                o.status = ST_NO_PORT;
                for (int i = 0; i < Ports; i++) begin
                    cand = scan_ptr;
                    scan_ptr = (cand == 0) ? PortW'(Ports - 1) : PortW'(cand - 1);
                    if (!q_alloc[cand]) begin
                        q_alloc[cand] = 1'b1;
                        q_len[cand] = 0;
                        q_cap[cand] = r.capacity;
                        o.status = ST_OK;
                        o.port_out = cand[3:0];
                        break;
                    end
                end
            end
            FUNC_SEND: begin
                if (!ok) o.status = ST_NOT_ALLOC;
                else if (q_len[p] >= q_cap[p]) o.status = ST_FULL;
                else if (free_cnt == 0) o.status = ST_NO_NODE;
                else begin
                    nd = free_head;
                    free_head = link_mem[nd];
                    free_cnt--;
                    word_mem[nd] = r.msg;
                    if (q_len[p] == 0) q_head[p] = nd;
                    else link_mem[q_tail[p]] = nd;
                    q_tail[p] = nd;
                    q_len[p]++;
                end
            end
            FUNC_RECEIVE: begin
                if (!ok) o.status = ST_NOT_ALLOC;
                else if (q_len[p] == 0) o.status = ST_EMPTY;
                else begin
                    nd = q_head[p];
                    o.msg_out = word_mem[nd];
                    q_head[p] = link_mem[nd];
                    link_mem[nd] = free_head;
                    free_head = nd;
                    if (free_cnt < Nodes) free_cnt++;
                    q_len[p]--;
                end
            end
            FUNC_COUNT: begin
                if (!ok) o.status = ST_NOT_ALLOC;
                else o.count_out = 9'(q_len[p]);
            end
            FUNC_DELETE, FUNC_RESET: begin
                if (!ok) o.status = ST_NOT_ALLOC;
                else begin
                    splice_free(p);
                    if (r.func == FUNC_DELETE) q_alloc[p] = 1'b0;
                end
            end
            default: o.status = ST_NOT_ALLOC;
        endcase
        return o;
    endfunction

    function automatic t_req make_req(logic [2:0] f, int p, int cap, logic [31:0] m);
        t_req r;
        r.func = f;
        r.port = 4'(p);
        r.capacity = 9'(cap);
        r.msg = m;
        return r;
    endfunction

    function automatic logic [2:0] rand_func();
        int k;
        k = $urandom_range(0, 99);
        if (k < 4) return FUNC_CREATE;
        if (k < 44) return FUNC_SEND;
        if (k < 80) return FUNC_RECEIVE;
        if (k < 88) return FUNC_COUNT;
        if (k < 92) return FUNC_DELETE;
        if (k < 97) return FUNC_RESET;
        return 3'($urandom_range(6, 7));
    endfunction

    initial begin
        int cap;
        for (int i = 0; i < Ports; i++) begin
            q_alloc[i] = 1'b0; q_len[i] = 0; q_cap[i] = 0;
            q_head[i] = '0; q_tail[i] = '0;
        end
        for (int i = 0; i < Nodes; i++) begin
            link_mem[i] = NodeW'((i + 1) % Nodes);
            word_mem[i] = '0;
        end
        free_head = '0;
        free_cnt = Nodes;
        scan_ptr = PortW'(Ports - 1);

        // directed: errors on unallocated ports, unknown funcs
        pending_reqs.push_back(make_req(FUNC_SEND, 0, 0, 32'h1));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 15, 0, 0));
        pending_reqs.push_back(make_req(FUNC_COUNT, 3, 0, 0));
        pending_reqs.push_back(make_req(FUNC_DELETE, 7, 0, 0));
        pending_reqs.push_back(make_req(FUNC_RESET, 8, 0, 0));
        pending_reqs.push_back(make_req(3'd6, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 15, 511, 32'hffffffff));
        // capacity zero is always full
        pending_reqs.push_back(make_req(FUNC_CREATE, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_SEND, 15, 0, 32'h5));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 15, 0, 0));
        // one-deep queue: full then empty
        pending_reqs.push_back(make_req(FUNC_CREATE, 0, 1, 0));
        pending_reqs.push_back(make_req(FUNC_SEND, 14, 0, 32'h80000000));
        pending_reqs.push_back(make_req(FUNC_SEND, 14, 0, 32'h7fffffff));
        pending_reqs.push_back(make_req(FUNC_COUNT, 14, 0, 0));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 14, 0, 0));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 14, 0, 0));
        pending_reqs.push_back(make_req(FUNC_SEND, 14, 0, 32'hffffffff));
        pending_reqs.push_back(make_req(FUNC_RESET, 14, 0, 0));
        pending_reqs.push_back(make_req(FUNC_COUNT, 14, 0, 0));
        pending_reqs.push_back(make_req(FUNC_DELETE, 15, 0, 0));
        // fill all ports, then no free port
        for (int i = 0; i < Ports - 1; i++)
            pending_reqs.push_back(make_req(FUNC_CREATE, 0, (i == 0) ? 256 : 300 + i, 0));
        pending_reqs.push_back(make_req(FUNC_CREATE, 0, 5, 0));
        // exhaust the node pool into the big ports
        for (int i = 0; i < Nodes + 4; i++)
            pending_reqs.push_back(make_req(FUNC_SEND, (i < 256) ? 13 : 12, 0, $urandom));
        pending_reqs.push_back(make_req(FUNC_SEND, 12, 0, 32'h0));
        pending_reqs.push_back(make_req(FUNC_COUNT, 13, 0, 0));
        pending_reqs.push_back(make_req(FUNC_DELETE, 13, 0, 0));
        // random: mostly valid ports, random content
        for (int n = 0; n < 800; n++) begin
            cap = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, 40);
            pending_reqs.push_back(make_req(rand_func(), $urandom_range(0, 15), cap, $urandom));
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) expected_rsps.push_back(queue_op(req_if.data));
            if (pending_reqs.size() > 0 && (quiet_send || $urandom_range(0, 99) >= 28)) begin
                req_if.valid <= 1'b1;
                req_if.data <= pending_reqs.pop_front();
            end else begin
                req_if.valid <= 1'b0;
                if (pending_reqs.size() == 0 && !req_if.valid) stim_done <= 1'b1;
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (!i_rst_n) hold_off <= 0;
        else if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer %p", got);
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
            rsp_if.ready <= (hold_off <= 1) && (quiet_recv || $urandom_range(0, 99) >= 28);
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 300;
        repeat (600) @(posedge i_clk);
        quiet_send <= 1'b1;
        quiet_recv <= 1'b1;
        repeat (1500) @(posedge i_clk);
        quiet_send <= 1'b0;
        quiet_recv <= 1'b0;
        wait (stim_done && expected_rsps.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

>>> multi_port_message_queue_manager.f
design/mpmq_pkg.sv
design/mpmq_if.sv
design/mpmq_node_mem.sv
design/multi_port_message_queue_manager.sv
bench/tb_multi_port_message_queue_manager.sv
